// File: sv/ftyp_brand_sniffer_assert.svh
// Assertion macros used by the checker file of the ftyp brand sniffer.
`ifndef FTYP_BRAND_SNIFFER_ASSERT_SVH
`define FTYP_BRAND_SNIFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FBS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FBS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: sv/fbs_pkg.sv
// Shared types and constants of the ftyp brand sniffer.
package fbs_pkg;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [POS_W-1:0] POS_SIZE_END  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TYPE_END  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LARGE_BEG = POS_W'(8);
    localparam logic [POS_W-1:0] POS_LARGE_END = POS_W'(15);

    localparam logic [POS_W-1:0] MINOR_END_STD   = POS_W'(15);
    localparam logic [POS_W-1:0] MINOR_END_LARGE = POS_W'(23);
    localparam logic [POS_W:0]   BODY_MIN_STD    = (POS_W+1)'(16);
    localparam logic [POS_W:0]   BODY_MIN_LARGE  = (POS_W+1)'(24);

    localparam logic [63:0] SIZE_LARGE   = 64'd1;
    localparam logic [63:0] MIN_SIZE_STD = 64'd16;
    localparam logic [63:0] MIN_SIZE_LRG = 64'd24;

    localparam logic [31:0] TAG_FTYP = 32'h6674_7970;
    localparam logic [31:0] TAG_MIF1 = 32'h6d69_6631;
    localparam logic [31:0] TAG_HEIC = 32'h6865_6963;
    localparam logic [31:0] TAG_MSF1 = 32'h6d73_6631;
    localparam logic [31:0] TAG_HEVC = 32'h6865_7663;
    localparam logic [31:0] TAG_AVIF = 32'h6176_6966;
    localparam logic [31:0] TAG_AVIS = 32'h6176_6973;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_HEIF = 2'd1,
        FMT_AVIF = 2'd2
    } fmt_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic give;
        fmt_t fmt;
    } result_t;

endpackage

// File: sv/fbs_input_stage.sv
// Input register that holds one byte transaction for the parser.
module fbs_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  logic [7:0]          data_byte,
    input  logic                end_of_data,
    input  logic                take,
    output logic                item_valid,
    output fbs_pkg::byte_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    fbs_pkg::byte_item_t item_reg;

    assign byte_ready = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_valid && byte_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= end_of_data;
        end
    end

endmodule

// File: sv/fbs_parser.sv
// Box header and brand parser state with its per-byte next-state logic.
module fbs_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  fbs_pkg::byte_item_t item,
    output fbs_pkg::result_t    result
);

    typedef enum logic [4:0] {
        PH_SIZE   = 5'b00001,
        PH_TYPE   = 5'b00010,
        PH_LARGE  = 5'b00100,
        PH_BRANDS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [fbs_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [63:0]               box_len_reg, box_len_next;
    logic [23:0]               word_reg, word_next;
    logic                      large_reg, large_next;
    logic                      heif_reg, heif_next;

    logic [31:0]               word_new;
    logic [63:0]               large_len;
    logic [fbs_pkg::POS_W:0]   pos_inc;
    logic [fbs_pkg::POS_W-1:0] minor_end;
    logic [fbs_pkg::POS_W:0]   body_min;
    logic                      parse_en;
    logic                      heif_now;
    logic                      give;
    fbs_pkg::fmt_t             fmt;

    assign word_new  = {word_reg, item.data};
    assign pos_inc   = {1'b0, pos_reg} + (fbs_pkg::POS_W+1)'(1);
    assign minor_end = large_reg ? fbs_pkg::MINOR_END_LARGE : fbs_pkg::MINOR_END_STD;
    assign body_min  = large_reg ? fbs_pkg::BODY_MIN_LARGE : fbs_pkg::BODY_MIN_STD;
    assign parse_en  = (phase_reg != PH_DONE) && (pos_reg != fbs_pkg::POS_MAX);
    assign large_len = (pos_reg == fbs_pkg::POS_LARGE_BEG) ? {56'd0, item.data}
                                                           : {box_len_reg[55:0], item.data};

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        box_len_next = box_len_reg;
        word_next    = word_reg;
        large_next   = large_reg;
        heif_now     = heif_reg;
        give         = 1'b0;
        fmt          = fbs_pkg::FMT_NONE;

        if (parse_en)
        begin
            word_next = word_new[23:0];
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (pos_reg == fbs_pkg::POS_SIZE_END)
                    begin
                        box_len_next = {32'd0, word_new};
                        phase_next   = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (pos_reg == fbs_pkg::POS_TYPE_END)
                    begin
                        if (word_new != fbs_pkg::TAG_FTYP)
                        begin
                            give = 1'b1;
                        end
                        else if (box_len_reg == fbs_pkg::SIZE_LARGE)
                        begin
                            large_next = 1'b1;
                            phase_next = PH_LARGE;
                        end
                        else if (box_len_reg < fbs_pkg::MIN_SIZE_STD)
                        begin
                            give = 1'b1;
                        end
                        else
                        begin
                            large_next = 1'b0;
                            phase_next = PH_BRANDS;
                        end
                    end
                end
                PH_LARGE:
                begin
                    box_len_next = large_len;
                    if (pos_reg == fbs_pkg::POS_LARGE_END)
                    begin
                        if (large_len < fbs_pkg::MIN_SIZE_LRG)
                        begin
                            give = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BRANDS;
                        end
                    end
                end
                PH_BRANDS:
                begin
                    // The minor version word is never compared against brands.
                    if ((pos_reg[1:0] == 2'b11) && (pos_reg != minor_end))
                    begin
                        if ((word_new == fbs_pkg::TAG_AVIF) || (word_new == fbs_pkg::TAG_AVIS))
                        begin
                            give = 1'b1;
                            fmt  = fbs_pkg::FMT_AVIF;
                        end
                        else if ((word_new == fbs_pkg::TAG_MIF1) ||
                                 (word_new == fbs_pkg::TAG_HEIC) ||
                                 (word_new == fbs_pkg::TAG_MSF1) ||
                                 (word_new == fbs_pkg::TAG_HEVC))
                        begin
                            heif_now = 1'b1;
                        end
                    end
                    if (!give && (box_len_reg == 64'(pos_inc)))
                    begin
                        give = 1'b1;
                        fmt  = heif_now ? fbs_pkg::FMT_HEIF : fbs_pkg::FMT_NONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (!give && item.last && (phase_reg != PH_DONE))
        begin
            give = 1'b1;
            fmt  = ((phase_next == PH_BRANDS) && (pos_inc >= body_min) && heif_now)
                   ? fbs_pkg::FMT_HEIF : fbs_pkg::FMT_NONE;
        end

        heif_next = heif_now;
        if (give)
        begin
            phase_next = PH_DONE;
        end

        if (item.last)
        begin
            phase_next   = PH_SIZE;
            pos_next     = '0;
            box_len_next = '0;
            word_next    = '0;
            large_next   = 1'b0;
            heif_next    = 1'b0;
        end
        else if (pos_reg != fbs_pkg::POS_MAX)
        begin
            pos_next = pos_inc[fbs_pkg::POS_W-1:0];
        end
    end

    assign result.give = step && give;
    assign result.fmt  = fmt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIZE;
            pos_reg     <= '0;
            box_len_reg <= '0;
            word_reg    <= '0;
            large_reg   <= 1'b0;
            heif_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            box_len_reg <= box_len_next;
            word_reg    <= word_next;
            large_reg   <= large_next;
            heif_reg    <= heif_next;
        end
    end

endmodule

// File: sv/fbs_result_stage.sv
// Output register that holds one verdict until the result transaction completes.
module fbs_result_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  fbs_pkg::result_t result,
    output logic             space,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             supported,
    output logic [1:0]       image_format
);

    logic          valid_reg;
    logic          valid_next;
    fbs_pkg::fmt_t fmt_reg;

    assign space        = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign image_format = fmt_reg;
    assign supported    = (fmt_reg != fbs_pkg::FMT_NONE);

    always_comb
    begin
        valid_next = valid_reg;
        if (result.give)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.give)
        begin
            fmt_reg <= result.fmt;
        end
    end

endmodule

// File: sv/ftyp_brand_sniffer.sv
// Top level of the ftyp brand sniffer: input register, parser and result register.
//
//   Channel   Signals                                   Role
//   byte      byte_valid, byte_ready, data_byte,        one file byte per transaction
//             end_of_data
//   result    result_valid, result_ready, supported,    at most one verdict per file
//             image_format
//
// One byte is taken per cycle while byte_ready is high; verdicts are registered after the parser.
// The parser updates its state from the byte held in the input register.
// Reset clears the parser to expect a new box size and empties both registers.
// While a verdict waits with result_ready low, one more byte is buffered and then
// byte_ready drops until the verdict is taken.
module ftyp_brand_sniffer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       supported,
    output logic [1:0] image_format
);

    fbs_pkg::byte_item_t item;
    fbs_pkg::result_t    result;
    logic                item_valid;
    logic                space;
    logic                step;

    assign step = item_valid && space;

    fbs_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .take        (step),
        .item_valid  (item_valid),
        .item        (item)
    );

    fbs_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    fbs_result_stage u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .supported    (supported),
        .image_format (image_format)
    );

endmodule

// File: sv/fbs_checker.sv
// Port-level assertion checker for the ftyp brand sniffer and its bind.
`include "ftyp_brand_sniffer_assert.svh"

module fbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_ready,
    input logic [7:0] data_byte,
    input logic       end_of_data,
    input logic       result_valid,
    input logic       result_ready,
    input logic       supported,
    input logic [1:0] image_format
);

    logic format_legal;
    logic byte_wait;
    logic result_wait;

    assign format_legal = (image_format == fbs_pkg::FMT_NONE) ||
                          (image_format == fbs_pkg::FMT_HEIF) ||
                          (image_format == fbs_pkg::FMT_AVIF);
    assign byte_wait    = byte_valid && !byte_ready;
    assign result_wait  = result_valid && !result_ready;

    `FBS_ASSERT_NOW(a_format_legal, result_valid, format_legal)
    `FBS_ASSERT_NOW(a_supported_match, result_valid, supported == (image_format != fbs_pkg::FMT_NONE))
    `FBS_ASSERT_NOW(a_stall_only_on_result, !byte_ready, result_wait)
    `FBS_ASSERT_NEXT(a_result_holds, result_wait, result_valid && $stable({supported, image_format}))
    `FBS_ASSERT_NEXT(a_byte_holds, byte_wait, byte_valid && $stable({data_byte, end_of_data}))

endmodule

bind ftyp_brand_sniffer fbs_checker u_fbs_checker (.*);

// File: tb/ftyp_brand_sniffer_tb.sv
// Self-checking testbench for the ftyp brand sniffer: byte streams in, verdicts checked.
`timescale 1ns / 100ps

module ftyp_brand_sniffer_tb;

    typedef enum logic [2:0] {
        SEEK_SIZE,
        SEEK_TYPE,
        SEEK_LARGE,
        SCAN_BRANDS,
        SETTLED
    } sniff_stage_t;

    class verdict_scoreboard;
        sniff_stage_t stage;
        logic [fbs_pkg::POS_W-1:0] offset;
        logic [63:0] box_size;
        logic [31:0] shifter;
        logic [4:0] body_base;
        logic heif_hit;
        logic settled;
        fbs_pkg::fmt_t pending_verdicts[$];
        int mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            stage = SEEK_SIZE;
            offset = '0;
            box_size = '0;
            shifter = '0;
            body_base = 5'd8;
            heif_hit = 1'b0;
            settled = 1'b0;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void predict_verdict(logic [7:0] b, logic last);
            logic [63:0] p;
            logic [63:0] rel;
            logic give;
            fbs_pkg::fmt_t fmt;
            p = 64'(offset);
            give = 1'b0;
            fmt = fbs_pkg::FMT_NONE;
            if (!settled && offset != fbs_pkg::POS_MAX)
            begin
                shifter = {shifter[23:0], b};
                case (stage)
                    SEEK_SIZE:
                    begin
                        if (p == 3)
                        begin
                            box_size = 64'(shifter);
                            stage = SEEK_TYPE;
                        end
                    end
                    SEEK_TYPE:
                    begin
                        if (p == 7)
                        begin
                            if (shifter != fbs_pkg::TAG_FTYP)
                            begin
                                give = 1'b1;
                            end
                            else if (box_size == fbs_pkg::SIZE_LARGE)
                            begin
                                body_base = 5'd16;
                                stage = SEEK_LARGE;
                            end
                            else if (box_size < fbs_pkg::MIN_SIZE_STD)
                            begin
                                give = 1'b1;
                            end
                            else
                            begin
                                body_base = 5'd8;
                                stage = SCAN_BRANDS;
                            end
                        end
                    end
                    SEEK_LARGE:
                    begin
                        box_size = ((p == 8) ? 64'd0 : (box_size << 8)) | 64'(b);
                        if (p == 15)
                        begin
                            if (box_size < fbs_pkg::MIN_SIZE_LRG)
                                give = 1'b1;
                            else
                                stage = SCAN_BRANDS;
                        end
                    end
                    SCAN_BRANDS:
                    begin
                        rel = p - 64'(body_base);
                        // The second word of the body is the minor version and is never matched.
                        if (rel[1:0] == 2'd3 && (rel >> 2) != 64'd1)
                        begin
                            if (shifter == fbs_pkg::TAG_AVIF || shifter == fbs_pkg::TAG_AVIS)
                            begin
                                give = 1'b1;
                                fmt = fbs_pkg::FMT_AVIF;
                            end
                            else if (shifter == fbs_pkg::TAG_MIF1 ||
                                     shifter == fbs_pkg::TAG_HEIC ||
                                     shifter == fbs_pkg::TAG_MSF1 ||
                                     shifter == fbs_pkg::TAG_HEVC)
                            begin
                                heif_hit = 1'b1;
                            end
                        end
                        if (!give && p + 64'd1 == box_size)
                        begin
                            give = 1'b1;
                            fmt = heif_hit ? fbs_pkg::FMT_HEIF : fbs_pkg::FMT_NONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (!give && last && !settled)
            begin
                give = 1'b1;
                fmt = (stage == SCAN_BRANDS && p + 64'd1 >= 64'(body_base) + 64'd8 && heif_hit)
                      ? fbs_pkg::FMT_HEIF : fbs_pkg::FMT_NONE;
            end
            if (give)
            begin
                pending_verdicts.push_back(fmt);
                settled = 1'b1;
                stage = SETTLED;
            end
            if (last)
                restart();
            else if (offset != fbs_pkg::POS_MAX)
                offset = offset + 1'b1;
        endfunction

        function void check_verdict(logic sup, logic [1:0] fmt);
            fbs_pkg::fmt_t want;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict: supported=%0b image_format=%0d", sup, fmt);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (sup !== (want != fbs_pkg::FMT_NONE) || fmt !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected supported=%0b image_format=%0d,",
                                 want != fbs_pkg::FMT_NONE, want,
                                 " got supported=%0b image_format=%0d", sup, fmt);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    logic [7:0] data_byte = 8'h00;
    logic end_of_data = 1'b0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic supported;
    logic [1:0] image_format;

    verdict_scoreboard sb = new();
    logic [7:0] file_bytes[$];
    int sent_bytes = 0;
    int stall_left = 0;
    logic calm = 1'b0;

    ftyp_brand_sniffer dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .data_byte(data_byte),
        .end_of_data(end_of_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .supported(supported),
        .image_format(image_format)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.predict_verdict(data_byte, end_of_data);
            if (result_valid && result_ready)
                sb.check_verdict(supported, image_format);
        end
    end

    always @(negedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            result_ready = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready = 1'b0;
        end
        else
        begin
            result_ready = 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                         : $urandom_range(1, 3);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [31:0] near_miss(logic [31:0] w);
        return w ^ (32'd1 << $urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_brand();
        case ($urandom_range(0, 15))
            0: return fbs_pkg::TAG_AVIF;
            1: return fbs_pkg::TAG_AVIS;
            2: return fbs_pkg::TAG_MIF1;
            3: return fbs_pkg::TAG_HEIC;
            4: return fbs_pkg::TAG_MSF1;
            5: return fbs_pkg::TAG_HEVC;
            6: return near_miss(fbs_pkg::TAG_AVIF);
            7: return near_miss(fbs_pkg::TAG_MIF1);
            8: return near_miss(fbs_pkg::TAG_HEVC);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_word(logic [31:0] w);
        file_bytes.push_back(w[31:24]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endfunction

    // Mostly well-formed ftyp boxes with random sizes and brands; some are truncated or noise.
    function automatic void build_random_file();
        logic large_hdr;
        int nbrands;
        int extra;
        int min_size;
        int natural;
        int cut;
        logic [63:0] size;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
            return;
        end
        large_hdr = ($urandom_range(0, 3) == 0);
        nbrands = $urandom_range(0, 5);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        min_size = large_hdr ? 24 : 16;
        natural = min_size + 4 * nbrands + extra;
        case ($urandom_range(0, 9))
            0: size = 64'($urandom_range(0, min_size - 1));
            1: size = large_hdr ? {$urandom, $urandom} : 64'($urandom);
            2: size = 64'($urandom_range(min_size, natural));
            default: size = 64'(natural);
        endcase
        push_word(large_hdr ? fbs_pkg::SIZE_LARGE[31:0] : size[31:0]);
        push_word(($urandom_range(0, 9) == 0) ? near_miss(fbs_pkg::TAG_FTYP) : fbs_pkg::TAG_FTYP);
        if (large_hdr)
        begin
            push_word(size[63:32]);
            push_word(size[31:0]);
        end
        push_word(pick_brand());
        push_word(($urandom_range(0, 3) == 0) ? pick_brand() : $urandom);
        repeat (nbrands) push_word(pick_brand());
        repeat (extra) file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid = 1'b1;
        data_byte = b;
        end_of_data = last;
        do
            @(posedge clk);
        while (!byte_ready);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic idle_until_drained();
        byte_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        file_bytes = {8'hFF};
        send_file();
        file_bytes.delete();
        push_word(32'd16);
        push_word(fbs_pkg::TAG_FTYP);
        push_word(fbs_pkg::TAG_AVIF);
        file_bytes.push_back(8'h00);
        send_file();
        file_bytes.delete();
        push_word(32'd24);
        push_word(fbs_pkg::TAG_FTYP ^ 32'd1);
        file_bytes.push_back(8'h00);
        send_file();
        idle_until_drained();

        while (sent_bytes < 1600)
        begin
            calm = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 19) == 0)
                idle_until_drained();
            build_random_file();
            send_file();
        end
        calm = 1'b0;

        idle_until_drained();
        repeat (8) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
